>>> design/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants for the sorted list insert/remove block
// Holds the default capacity, the op and status codes, and the command and
// flag bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

    // Default number of stored values
    localparam int CAPACITY_DEF = 16;

    // Transaction payload widths
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int S_DATA_W = 40;   // op (1) + value (32), padded to bytes
    localparam int M_DATA_W = 40;   // status (2) + count (5) + smallest (32), padded

    // Operation codes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // Memory read address select
    typedef enum logic [1:0] {
        RD_IDX_M1 = 2'd0,
        RD_IDX    = 2'd1,
        RD_IDX_P1 = 2'd2,
        RD_ZERO   = 2'd3
    } rd_sel_t;

    // Memory write data select
    typedef enum logic {
        WR_RDATA = 1'b0,
        WR_VALUE = 1'b1
    } wr_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;          // latch a new input transaction
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;         // write at the index pointer
        wr_sel_t wr_sel;
        logic    idx_inc;
        logic    idx_dec;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    st_wr;         // overrides the status set by load
        status_t st_code;
        logic    cap_smallest;  // take read data as smallest
        logic    zero_smallest;
    } sli_cmd_t;

    // Datapath to controller flags
    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic idx_at_count;
        logic idx_last;         // idx + 1 >= count
        logic rd_ge;            // read data >= value
        logic rd_eq;            // read data == value
    } sli_flags_t;

endpackage

`default_nettype wire

>>> design/sli_datapath.sv
// ----------------------------------------------------------------------------
// sli_datapath: storage and arithmetic of the sorted list
// Single-port-write, registered-read value memory, index pointer, fill count,
// latched input transaction and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_datapath #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       in_op,
    input  wire  [31:0]               in_value,
    input  wire sli_pkg::sli_cmd_t    cmd,
    output sli_pkg::sli_flags_t       flags,
    output logic [1:0]                res_status,
    output logic [4:0]                res_count,
    output logic [31:0]               res_smallest
);
    import sli_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

    // Value memory
    logic signed [VALUE_W-1:0] mem [CAPACITY];
    logic signed [VALUE_W-1:0] rdata_reg;

    logic signed [VALUE_W-1:0] value_reg;
    logic [CW-1:0]             idx_reg;
    logic [CW-1:0]             idx_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    status_t                   status_reg;
    logic signed [VALUE_W-1:0] smallest_reg;

    logic [CW-1:0]             rd_idx;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic [CW:0]               idx_plus1;
    logic [XW-1:0]             count_ext;

    // Read address and write data selection
    always_comb begin
        case (cmd.rd_sel)
            RD_IDX_M1: rd_idx = idx_reg - CW'(1);
            RD_IDX:    rd_idx = idx_reg;
            RD_IDX_P1: rd_idx = idx_reg + CW'(1);
            default:   rd_idx = '0;
        endcase
    end

    assign rd_addr = rd_idx[AW-1:0];
    assign wr_data = (cmd.wr_sel == WR_VALUE) ? value_reg : rdata_reg;

    // Memory write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[idx_reg[AW-1:0]] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Index and count updates
    always_comb begin
        idx_next = idx_reg;
        if (cmd.load) begin
            idx_next = (op_t'(in_op) == OP_REMOVE) ? '0 : count_reg;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + CW'(1);
        end else if (cmd.idx_dec) begin
            idx_next = idx_reg - CW'(1);
        end

        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load) begin
            value_reg <= in_value;
        end
        if (cmd.st_wr) begin
            status_reg <= cmd.st_code;
        end else if (cmd.load) begin
            status_reg <= ST_DONE;
        end
        if (cmd.zero_smallest) begin
            smallest_reg <= '0;
        end else if (cmd.cap_smallest) begin
            smallest_reg <= rdata_reg;
        end
    end

    // Flags for the controller
    assign idx_plus1          = {1'b0, idx_reg} + (CW+1)'(1);
    assign flags.full         = (count_reg == CW'(CAPACITY));
    assign flags.empty        = (count_reg == '0);
    assign flags.idx_zero     = (idx_reg == '0);
    assign flags.idx_at_count = (idx_reg == count_reg);
    assign flags.idx_last     = (idx_plus1 >= {1'b0, count_reg});
    assign flags.rd_ge        = (rdata_reg >= value_reg);
    assign flags.rd_eq        = (rdata_reg == value_reg);

    // Result fields
    assign count_ext    = XW'(count_reg);
    assign res_status   = status_reg;
    assign res_count    = count_ext[COUNT_W-1:0];
    assign res_smallest = smallest_reg;

endmodule

`default_nettype wire

>>> design/sli_ctrl.sv
// ----------------------------------------------------------------------------
// sli_ctrl: sequencer of the sorted list
// One-hot state machine that walks the memory for each transaction: shift up
// from the top for an insert, search then shift down for a remove, and a
// final read of the head entry for the smallest value.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire                  in_op,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    input  wire sli_pkg::sli_flags_t flags,
    output sli_pkg::sli_cmd_t    cmd
);
    import sli_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_INS_RD = 11'b000_0000_0010,
        S_INS_CM = 11'b000_0000_0100,
        S_INS_WR = 11'b000_0000_1000,
        S_REM_RD = 11'b000_0001_0000,
        S_REM_CM = 11'b000_0010_0000,
        S_SH_RD  = 11'b000_0100_0000,
        S_SH_WR  = 11'b000_1000_0000,
        S_SM_RD  = 11'b001_0000_0000,
        S_SM_CAP = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_IDX;
        cmd.wr_sel = WR_RDATA;
        cmd.st_code = ST_DONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (op_t'(in_op) == OP_INSERT) begin
                        if (flags.full) begin
                            cmd.st_wr   = 1'b1;
                            cmd.st_code = ST_FULL;
                            state_next  = S_SM_RD;
                        end else begin
                            state_next = S_INS_RD;
                        end
                    end else begin
                        if (flags.empty) begin
                            cmd.st_wr   = 1'b1;
                            cmd.st_code = ST_NOT_FOUND;
                            state_next  = S_SM_RD;
                        end else begin
                            state_next = S_REM_RD;
                        end
                    end
                end
            end
            // Insert: walk down from the top, moving entries >= value up one
            S_INS_RD: begin
                if (flags.idx_zero) begin
                    state_next = S_INS_WR;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_M1;
                    state_next = S_INS_CM;
                end
            end
            S_INS_CM: begin
                if (flags.rd_ge) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_RDATA;
                    cmd.idx_dec = 1'b1;
                    state_next  = S_INS_RD;
                end else begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_VALUE;
                cmd.cnt_inc = 1'b1;
                state_next  = S_SM_RD;
            end
            // Remove: search up for the first equal entry
            S_REM_RD: begin
                if (flags.idx_at_count) begin
                    cmd.st_wr   = 1'b1;
                    cmd.st_code = ST_NOT_FOUND;
                    state_next  = S_SM_RD;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_REM_CM;
                end
            end
            S_REM_CM: begin
                if (flags.rd_eq) begin
                    state_next = S_SH_RD;
                end else if (!flags.rd_ge) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_REM_RD;
                end else begin
                    cmd.st_wr   = 1'b1;
                    cmd.st_code = ST_NOT_FOUND;
                    state_next  = S_SM_RD;
                end
            end
            // Close the gap by moving later entries down one
            S_SH_RD: begin
                if (flags.idx_last) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_SM_RD;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_P1;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_RDATA;
                cmd.idx_inc = 1'b1;
                state_next  = S_SH_RD;
            end
            // Fetch the head entry for the smallest value
            S_SM_RD: begin
                if (flags.empty) begin
                    cmd.zero_smallest = 1'b1;
                    state_next        = S_OUT;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ZERO;
                    state_next = S_SM_CAP;
                end
            end
            S_SM_CAP: begin
                cmd.cap_smallest = 1'b1;
                state_next       = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/sorted_list_insert_remove.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove: sorted store of signed values with insert/remove
//
// Input channel (s_*): one transaction carries an op (insert or remove) and a
// signed 32-bit value. Output channel (m_*): exactly one result transaction
// per input, with status (done, full, not found), the count after the op and
// the smallest stored value (0 when empty).
// Values live in a CAPACITY-entry memory with one write and one registered
// read per cycle. One transaction at a time is handled: s_tready is high
// only while the block is idle. An insert walks down from the top moving
// larger-or-equal entries up, a read then a write per entry moved; a remove
// searches up, reading and comparing each entry passed, then moves later
// entries down, a read then a write each. An insert on a full store or a
// remove on an empty one skips the walk and goes straight to the head read.
// The result is held in registers with m_tvalid high until m_tready; the
// next input is taken the cycle after the result is accepted.
// Reset (aresetn low, synchronous) empties the store and returns to idle; no
// memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_remove #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // s_tdata: [0] op, [32:1] value, [39:33] zero
    input  wire  [sli_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // m_tdata: [1:0] status, [6:2] count, [38:7] smallest, [39] zero
    output logic [sli_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tvalid,
    input  wire                            m_tready
);
    import sli_pkg::*;

    sli_cmd_t   cmd;
    sli_flags_t flags;
    logic [1:0]  res_status;
    logic [4:0]  res_count;
    logic [31:0] res_smallest;

    sli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (s_tdata[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    sli_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_op        (s_tdata[0]),
        .in_value     (s_tdata[32:1]),
        .cmd          (cmd),
        .flags        (flags),
        .res_status   (res_status),
        .res_count    (res_count),
        .res_smallest (res_smallest)
    );

    // Result packing
    assign m_tdata = {1'b0, res_smallest, res_count, res_status};

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the sorted list insert/remove block
// Sends insert and remove transactions on the s_ stream and keeps its own
// sorted copy of the store to predict status, count and smallest value for
// every transaction. Each result on the m_ stream is checked field by field
// in order. Both sides idle at random; the receiver also holds off for long
// stretches, and the sender sometimes pauses until all results are back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sli_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int MAX_CYCLES = 1_000_000;
    localparam int TAIL       = 2 * CAP + 10;   // worst-case latency plus margin
    localparam int HOLD_LEN   = 300;

    // Expected outcome of one transaction
    typedef struct packed {
        status_t             status;
        logic [COUNT_W-1:0]  count;
        logic signed [31:0]  smallest;
    } outcome_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic [S_DATA_W-1:0]    s_tdata  = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    // Shadow copy of the sorted store and the pending outcomes
    logic signed [31:0]     sorted_vals[$];
    outcome_t               pending_outcomes[$];
    outcome_t               want;

    // Idle controls shared by the test tasks and the drivers
    bit                     tx_idle_en   = 1'b1;
    bit                     rx_stall_en  = 1'b1;
    int                     hold_left    = 0;
    int                     rx_stall_left = 0;
    int                     rx_roll;

    int                     n_errors     = 0;
    int                     n_cycles     = 0;
    int                     n_inserts    = 0;
    int                     n_removes    = 0;
    int                     n_full_drops = 0;
    int                     n_misses     = 0;
    int                     n_at_full    = 0;
    int                     n_at_empty   = 0;

    sorted_list_insert_remove #(
        .CAPACITY (CAP)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run-away guard
    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > MAX_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     n_cycles, pending_outcomes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Apply one operation to the shadow store and return what the block
    // should report for it
    function automatic outcome_t apply_to_store(op_t op, logic signed [31:0] v);
        outcome_t r;
        int       pos;
        r.status = ST_DONE;
        pos = 0;
        if (op == OP_INSERT) begin
            if (sorted_vals.size() >= CAP) begin
                r.status = ST_FULL;
            end else begin
                // in front of the first entry >= v
                while (pos < sorted_vals.size() && sorted_vals[pos] < v) pos++;
                sorted_vals.insert(pos, v);
            end
        end else begin
            // first equal entry goes
            while (pos < sorted_vals.size() && sorted_vals[pos] != v) pos++;
            if (pos >= sorted_vals.size())
                r.status = ST_NOT_FOUND;
            else
                sorted_vals.delete(pos);
        end
        r.count    = COUNT_W'(sorted_vals.size());
        r.smallest = (sorted_vals.size() > 0) ? sorted_vals[0] : 32'sd0;
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Values that matter for ordering, plus plain random ones
    function automatic logic [31:0] pick_value(bit for_remove);
        int roll;
        roll = $urandom_range(0, 99);
        if (for_remove && sorted_vals.size() > 0 && roll < 60)
            return sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
        if (!for_remove && sorted_vals.size() > 0 && roll < 15)
            return sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
        if (roll < 70) begin
            case ($urandom_range(0, 11))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h8000_0001;
                3:       return 32'h7FFF_FFFE;
                4:       return 32'h0000_0000;
                5:       return 32'hFFFF_FFFF;
                6:       return 32'h0000_0001;
                7:       return 32'hFFFF_FFFE;
                8:       return 32'h0000_0064;
                9:       return 32'hFFFF_FF9C;
                10:      return 32'h0000_0007;
                default: return 32'h0000_0002;
            endcase
        end
        return $urandom;
    endfunction

    // Send one transaction and record its expected outcome on acceptance
    task automatic send_item(op_t op, logic [31:0] value);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tdata  = {7'd0, value, op};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_outcomes.push_back(apply_to_store(op, value));
        if (op == OP_INSERT) n_inserts++;
        else                 n_removes++;
        if (pending_outcomes[$].status == ST_FULL)      n_full_drops++;
        if (pending_outcomes[$].status == ST_NOT_FOUND) n_misses++;
        if (sorted_vals.size() == CAP)                  n_at_full++;
        if (sorted_vals.size() == 0)                    n_at_empty++;
    endtask

    // Stop offering and wait until every result is back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls, or a counted hold-off when requested
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (!rx_stall_en) begin
            m_tready = 1'b1;
        end else if (rx_stall_left > 0) begin
            m_tready = 1'b0;
            rx_stall_left--;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70) begin
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b0;
                rx_stall_left = pick_gap();
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result transaction, tdata=%h", m_tdata);
                n_errors++;
            end else begin
                want = pending_outcomes.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    n_errors++;
                end
                if (m_tdata[6:2] !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, m_tdata[6:2]);
                    n_errors++;
                end
                if (m_tdata[38:7] !== want.smallest) begin
                    $error("smallest: expected %0d, got %0d",
                           want.smallest, $signed(m_tdata[38:7]));
                    n_errors++;
                end
            end
        end
    end

    // Empty remove, extremes, duplicates, absent value, fill to full
    task automatic test_directed();
        send_item(OP_REMOVE, 32'd5);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'd5);
        send_item(OP_INSERT, 32'd5);
        send_item(OP_REMOVE, 32'd3);
        send_item(OP_REMOVE, 32'd5);
        send_item(OP_REMOVE, 32'h8000_0000);
        for (int i = 0; i < 12; i++)
            send_item(OP_INSERT, 32'(i * 3 - 10));
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_REMOVE, 32'h7FFF_FFFF);
        drain_results();
    endtask

    // Bursts that lean toward filling or draining, so the store swings
    // between empty and full; some bursts end with a pause for all results
    task automatic test_random_mix(int n_items);
        int sent;
        int burst;
        int burst_len;
        int ins_pct;
        bit is_ins;
        sent  = 0;
        burst = 0;
        while (sent < n_items) begin
            case (burst % 5)
                0:       ins_pct = 80;
                1:       ins_pct = 25;
                2:       ins_pct = 50;
                3:       ins_pct = 95;
                default: ins_pct = 8;
            endcase
            burst_len = $urandom_range(10, 50);
            for (int i = 0; i < burst_len && sent < n_items; i++) begin
                is_ins = ($urandom_range(0, 99) < ins_pct);
                send_item(is_ins ? OP_INSERT : OP_REMOVE, pick_value(!is_ins));
                sent++;
            end
            if (burst % 7 == 6) drain_results();
            burst++;
        end
        drain_results();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_hold_off();
        tx_idle_en = 1'b0;
        hold_left  = HOLD_LEN;
        for (int i = 0; i < 16; i++)
            send_item((i % 3 == 2) ? OP_REMOVE : OP_INSERT, pick_value(i % 3 == 2));
        tx_idle_en = 1'b1;
        drain_results();
    endtask

    // Back-to-back transactions with the receiver always ready
    task automatic test_full_rate(int n_items);
        bit is_ins;
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        for (int i = 0; i < n_items; i++) begin
            is_ins = ($urandom_range(0, 99) < ((i / 40) % 2 ? 30 : 75));
            send_item(is_ins ? OP_INSERT : OP_REMOVE, pick_value(!is_ins));
        end
        drain_results();
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_mix(1300);
        test_hold_off();
        test_full_rate(400);

        drain_results();
        repeat (TAIL) @(posedge aclk);

        $display("Checked %0d inserts and %0d removes: %0d dropped as full, %0d not found.",
                 n_inserts, n_removes, n_full_drops, n_misses);
        $display("Store reached full %0d times and empty %0d times in %0d cycles.",
                 n_at_full, n_at_empty, n_cycles);
        if (n_errors == 0 && pending_outcomes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors,
                     pending_outcomes.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
